// ----- hw/rtl/lirs_pkg.sv -----
// Shared widths, constants and controller/datapath interface types for the resampler.
package lirs_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int FRAC_BITS    = 16;
   localparam int STEP_WIDTH   = FRAC_BITS + 4;
   localparam int PHASE_WIDTH  = FRAC_BITS + 5;
   localparam int PROD_WIDTH   = SAMPLE_WIDTH + FRAC_BITS + 2;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [STEP_WIDTH-1:0]          step_type;
   typedef logic [PHASE_WIDTH-1:0]         phase_type;

   localparam step_type  STEP_RESET = step_type'(1) << FRAC_BITS;
   localparam step_type  STEP_MIN   = step_type'(1) << (FRAC_BITS - 5);
   localparam phase_type PHASE_ONE  = phase_type'(1) << FRAC_BITS;
   localparam phase_type PHASE_TWO  = phase_type'(1) << (FRAC_BITS + 1);

   typedef struct packed {
      logic load_in;
      logic calc_product;
      logic emit_interp;
      logic emit_tail;
      logic drop_one;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic have_prev;
      logic last;
      logic phase_ge_one;
      logic next_ge_one;
      logic out_free;
   } status_type;

endpackage

// ----- hw/rtl/lirs_datapath.sv -----
// Datapath: step register, sample and phase state, multiplier and output register.
module lirs_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  lirs_pkg::cmd_type              cmd,
   output lirs_pkg::status_type           status,
   input  logic [lirs_pkg::SAMPLE_WIDTH-1:0] req_tdata,
   input  logic                           req_tlast,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lirs_pkg::STEP_WIDTH-1:0] csr_data,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [lirs_pkg::SAMPLE_WIDTH-1:0] rsp_tdata,
   output logic                           rsp_tlast
);
   import lirs_pkg::*;

   step_type   step_ff, step_in;
   sample_type cur_ff, cur_in;
   logic       last_ff, last_in;
   sample_type prev_ff, prev_in;
   logic       have_prev_ff, have_prev_in;
   phase_type  phase_ff, phase_in;
   logic signed [PROD_WIDTH-1:0] product_ff, product_in;
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;

   step_type   eff_step;
   phase_type  phase_next;
   logic       next_ge_one;
   logic       next_lt_two;
   logic signed [SAMPLE_WIDTH:0]   diff;
   logic signed [FRAC_BITS:0]      frac;
   logic signed [PROD_WIDTH-1:0]   product_full;
   logic signed [PROD_WIDTH-1:0]   shifted;
   logic signed [SAMPLE_WIDTH:0]   interp;

   assign csr_ready = 1'b1;

   always_comb begin
      eff_step     = (step_ff < STEP_MIN) ? STEP_MIN : step_ff;
      phase_next   = phase_ff + PHASE_WIDTH'(eff_step);
      next_ge_one  = (phase_next >= PHASE_ONE);
      next_lt_two  = (phase_next < PHASE_TWO);
      diff         = {cur_ff[SAMPLE_WIDTH-1], cur_ff} - {prev_ff[SAMPLE_WIDTH-1], prev_ff};
      frac         = {1'b0, phase_ff[FRAC_BITS-1:0]};
      product_full = diff * frac;
      // The arithmetic shift floors, so the result stays between the two samples.
      shifted      = product_ff >>> FRAC_BITS;
      interp       = {prev_ff[SAMPLE_WIDTH-1], prev_ff} + shifted[SAMPLE_WIDTH:0];
   end

   always_comb begin
      step_in      = csr_valid ? csr_data : step_ff;
      cur_in       = cmd.load_in ? sample_type'(req_tdata) : cur_ff;
      last_in      = cmd.load_in ? req_tlast : last_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      phase_in     = phase_ff;
      product_in   = cmd.calc_product ? product_full : product_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.emit_interp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = interp[SAMPLE_WIDTH-1:0];
         // Last transfer of the item unless the tail on a final sample still has work.
         rsp_last_in  = next_ge_one & ~(last_ff & next_lt_two);
         phase_in     = next_ge_one ? (phase_next - PHASE_ONE) : phase_next;
      end
      if (cmd.emit_tail) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = cur_ff;
         rsp_last_in  = next_ge_one;
         phase_in     = phase_next;
      end
      if (cmd.drop_one) begin
         phase_in = phase_ff - PHASE_ONE;
      end
      if (cmd.commit) begin
         if (last_ff) begin
            prev_in      = '0;
            have_prev_in = 1'b0;
            phase_in     = '0;
         end else begin
            prev_in      = cur_ff;
            have_prev_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_RESET;
         last_ff      <= 1'b0;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         last_ff      <= last_in;
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      product_ff  <= product_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      status.have_prev    = have_prev_ff;
      status.last         = last_ff;
      status.phase_ge_one = (phase_ff >= PHASE_ONE);
      status.next_ge_one  = next_ge_one;
      status.out_free     = ~rsp_valid_ff | rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- hw/rtl/lirs_ctrl.sv -----
// Controller: sequences one input sample through interpolation and tail outputs.
module lirs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  lirs_pkg::status_type status,
   output lirs_pkg::cmd_type    cmd
);
   import lirs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_MUL,
      S_EMIT,
      S_TAILCHK,
      S_TAIL,
      S_COMMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.have_prev && !status.phase_ge_one) begin
               state_in = S_MUL;
            end else begin
               // A phase already past the interval only loses one whole sample.
               cmd.drop_one = status.have_prev;
               state_in     = S_TAILCHK;
            end
         end
         S_MUL: begin
            cmd.calc_product = 1'b1;
            state_in         = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit_interp = 1'b1;
               state_in        = status.next_ge_one ? S_TAILCHK : S_MUL;
            end
         end
         S_TAILCHK: begin
            state_in = (status.last && !status.phase_ge_one) ? S_TAIL : S_COMMIT;
         end
         S_TAIL: begin
            if (status.out_free) begin
               cmd.emit_tail = 1'b1;
               if (status.next_ge_one) begin
                  state_in = S_COMMIT;
               end
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/linear_interp_resampler.sv -----
// One-channel linear interpolation resampler, step given as an unsigned Q4.16 phase increment.
// Each input sample passes through the idle, check, tail check and commit states, plus a
// multiply through the single shared multiplier and then the add into the output register
// for every interpolated output and a pass through the tail state for every repeated output
// after a final sample; an output waiting on rsp_tready stalls the sequence. Input is
// refused while a sample is being worked on, so upsampling holds the input side for the
// length of its burst. The phase step is written on the csr port, which is always ready,
// and is used from then on, also by a sample in work; steps below 1/32 behave as 1/32.
module linear_interp_resampler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lirs_pkg::SAMPLE_WIDTH-1:0] req_tdata,  // [15:0] in_sample
   input  logic                              req_tlast,  // in_last
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lirs_pkg::SAMPLE_WIDTH-1:0] rsp_tdata,  // [15:0] out_sample
   output logic                              rsp_tlast,  // run_end
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lirs_pkg::STEP_WIDTH-1:0]   csr_data    // [19:0] phase_step
);
   import lirs_pkg::*;

   cmd_type    cmd;
   status_type status;

   lirs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lirs_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- hw/rtl/lirs_checker.sv -----
// Port-level checks on the resampler and the bind that attaches them.
module lirs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [lirs_pkg::SAMPLE_WIDTH-1:0] rsp_tdata,
   input logic                              rsp_tlast,
   input logic                              csr_ready
);

   // The output register is empty straight after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // One sample is worked on at a time: a transfer in closes the input side next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while a sample is in work");

   // The phase step register can always be written.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration port not ready");

endmodule

bind linear_interp_resampler lirs_checker u_lirs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_ready  (csr_ready)
);

// ----- tb/tb_linear_interp_resampler.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the linear interpolation resampler with its own output predictor.
module tb_linear_interp_resampler;
   import lirs_pkg::*;

   localparam int CLK_HALF     = 6;
   localparam int RESET_CYCLES = 5;
   localparam int MAX_BURST    = 64;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 16;
   localparam int IDLE_PCT     = 35;
   localparam int RAND_PHASES  = 6;
   localparam int PHASE_ITEMS  = 27;

   typedef struct packed {
      sample_type sample;
      logic       last;
   } in_sample_type;

   typedef struct packed {
      sample_type sample;
      logic       run_end;
   } out_sample_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [SAMPLE_WIDTH-1:0] req_tdata  = '0;
   logic                    req_tlast  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [SAMPLE_WIDTH-1:0] rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [STEP_WIDTH-1:0]   csr_data   = '0;

   // Predictor state, a copy of what the block keeps between samples.
   step_type    step_setting = STEP_RESET;
   sample_type  held_sample  = '0;
   logic        held_valid   = 1'b0;
   phase_type   phase_pos    = '0;

   in_sample_type  pending_samples[$];
   out_sample_type expected_outputs[$];
   in_sample_type  next_item;
   out_sample_type oldest;

   bit          req_taken    = 1'b0;
   int          idle_pct     = IDLE_PCT;
   int          quiet_cycles = 0;
   int          errors       = 0;
   int          samples_in   = 0;
   int          outputs_seen = 0;
   int          step_writes  = 0;

   linear_interp_resampler i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   // Works out every output that one accepted input sample causes.
   task automatic predict_outputs(input sample_type cur, input logic last);
      out_sample_type burst[$];
      step_type    step;
      longint      diff;
      longint      prod;
      step = (step_setting < STEP_MIN) ? STEP_MIN : step_setting;
      if (held_valid) begin
         diff = longint'(cur) - longint'(held_sample);
         while (phase_pos < PHASE_ONE && burst.size() < MAX_BURST) begin
            prod = diff * longint'(phase_pos);
            burst.push_back('{sample: sample_type'(longint'(held_sample) + (prod >>> FRAC_BITS)),
                              run_end: 1'b0});
            phase_pos += step;
         end
         if (phase_pos >= PHASE_ONE)
            phase_pos -= PHASE_ONE;
         else
            phase_pos = '0;
      end
      if (last) begin
         // The tail of the stream repeats the final sample as it stands.
         while (phase_pos < PHASE_ONE && burst.size() < MAX_BURST) begin
            burst.push_back('{sample: cur, run_end: 1'b0});
            phase_pos += step;
         end
         held_sample = '0;
         held_valid  = 1'b0;
         phase_pos   = '0;
      end else begin
         held_sample = cur;
         held_valid  = 1'b1;
      end
      if (burst.size() != 0)
         burst[burst.size()-1].run_end = 1'b1;
      foreach (burst[k])
         expected_outputs.push_back(burst[k]);
   endtask

   // Monitor: samples every transfer at the rising edge and checks results.
   always @(posedge clock) begin
      req_taken = (req_tvalid && req_tready) === 1'b1;
      if (!reset) begin
         if (req_taken) begin
            predict_outputs(sample_type'(req_tdata), req_tlast);
            samples_in++;
         end
         if ((rsp_tvalid && rsp_tready) === 1'b1) begin
            outputs_seen++;
            if (expected_outputs.size() == 0) begin
               $error("unexpected output: out_sample %0d run_end %0b",
                      $signed(rsp_tdata), rsp_tlast);
               errors++;
            end else begin
               oldest = expected_outputs.pop_front();
               if (rsp_tdata !== oldest.sample) begin
                  $error("out_sample mismatch: expected %0d, actual %0d",
                         oldest.sample, $signed(rsp_tdata));
                  errors++;
               end
               if (rsp_tlast !== oldest.run_end) begin
                  $error("run_end mismatch: expected %0b, actual %0b",
                         oldest.run_end, rsp_tlast);
                  errors++;
               end
            end
         end
         if ((csr_valid && csr_ready) === 1'b1) begin
            step_setting = step_type'(csr_data);
            step_writes++;
         end
         if (req_taken || (rsp_tvalid && rsp_tready) === 1'b1 ||
             (csr_valid && csr_ready) === 1'b1)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_linear_interp_resampler: FAIL");
            $finish;
         end
      end
   end

   // Driver: presents queued samples and a randomly stalling receiver at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
         if (req_taken || !req_tvalid) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
               next_item = pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_item.sample;
               req_tlast  <= next_item.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic queue_sample(input sample_type value, input logic last);
      pending_samples.push_back('{sample: value, last: last});
   endtask

   // Holds the sender back until every queued sample has gone and every output has come.
   task automatic wait_idle();
      while (pending_samples.size() != 0 || req_tvalid || expected_outputs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_step(input step_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random_streams(input int count);
      int         remaining;
      int         len;
      sample_type value;
      remaining = count;
      while (remaining > 0) begin
         len = $urandom_range(1, 12);
         if (len > remaining)
            len = remaining;
         for (int k = 0; k < len; k++) begin
            case ($urandom_range(9))
               0:       value = 16'sh7FFF;
               1:       value = 16'sh8000;
               default: value = sample_type'($urandom);
            endcase
            queue_sample(value, k == len - 1);
         end
         remaining -= len;
      end
   endtask

   initial begin
      step_type step;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset step of 1.0: a lone final sample, then a stream swinging between the extremes.
      queue_sample(16'sh7FFF, 1'b1);
      queue_sample(16'sh8000, 1'b0);
      queue_sample(16'sh7FFF, 1'b0);
      queue_sample(16'sh8000, 1'b0);
      queue_sample(-16'sd1, 1'b0);
      queue_sample(16'sd0, 1'b0);
      queue_sample(16'sd12345, 1'b1);
      wait_idle();

      // Smallest step: full bursts of interpolated and repeated outputs.
      write_step(STEP_MIN);
      queue_sample(16'sh8000, 1'b0);
      queue_sample(16'sh7FFF, 1'b1);
      queue_sample(16'sd100, 1'b1);
      wait_idle();

      // Largest step: downsampling, most intervals emit nothing.
      write_step(step_type'((1 << STEP_WIDTH) - 1));
      queue_sample(16'sd1, 1'b0);
      queue_sample(-16'sd2, 1'b0);
      queue_sample(16'sd3, 1'b0);
      queue_sample(16'sh8000, 1'b0);
      queue_sample(16'sh7FFF, 1'b1);
      wait_idle();

      // A step of zero and one below range both behave as the minimum step.
      write_step('0);
      queue_sample(-16'sd5, 1'b0);
      queue_sample(16'sd7, 1'b1);
      wait_idle();
      write_step(step_type'(1000));
      queue_sample(16'sh7FFF, 1'b0);
      queue_sample(16'sh8000, 1'b1);
      wait_idle();

      write_step(step_type'(32768));
      queue_sample(16'sh8000, 1'b0);
      queue_sample(16'sh7FFF, 1'b0);
      queue_sample(16'sd0, 1'b1);
      wait_idle();

      for (int p = 0; p < RAND_PHASES; p++) begin
         case ($urandom_range(3))
            0:       step = step_type'($urandom_range(2048, 32767));
            1:       step = step_type'($urandom_range(32768, 131071));
            2:       step = step_type'($urandom_range(131072, 1048575));
            default: step = step_type'($urandom_range(0, 2047));
         endcase
         write_step(step);
         // One phase runs with both sides at full speed.
         idle_pct = (p == 2) ? 0 : IDLE_PCT;
         queue_random_streams(PHASE_ITEMS);
         wait_idle();
      end

      if (expected_outputs.size() != 0) begin
         $error("%0d expected outputs never arrived", expected_outputs.size());
         errors++;
      end
      $display("Run covered %0d input samples and %0d checked output samples", samples_in,
               outputs_seen);
      $display("across %0d phase step writes, including the extremes and steps below range.",
               step_writes);
      if (errors == 0)
         $display("tb_linear_interp_resampler: PASS");
      else
         $display("tb_linear_interp_resampler: FAIL");
      $finish;
   end

endmodule
